// File: hdl/csp_pkg.sv
// shared types and constants for the curve subdivision pass unit
// depends on nothing; used by every module under hdl
package csp_pkg;

    localparam int COORD_W     = 16;
    localparam int QUEUE_DEPTH = 4;

    typedef logic signed [COORD_W-1:0] coord_t;

    // one input beat: a curve point and its end mark
    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        logic   curve_end;
    } point_beat_t;

    // one output beat: an emitted point
    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        logic   is_midpoint;
        logic   out_last;
    } result_beat_t;

    // work handed from the front to the back for one accepted point
    typedef struct packed {
        coord_t older_x;
        coord_t older_y;
        coord_t newer_x;
        coord_t newer_y;
        coord_t pt_x;
        coord_t pt_y;
        logic   emit_pair;      // vertex plus midpoint to the new point
        logic   vertex_smooth;  // vertex is interior, otherwise the start point
        logic   emit_final;     // new point closes the curve
    } cmd_t;

endpackage

// File: hdl/csp_front.sv
// front end: takes curve points, tracks the point window, classifies work
// depends on csp_pkg
module csp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                point_valid,
    output logic                point_stall,
    input  csp_pkg::point_beat_t point,
    input  logic                queue_full,
    output logic                push,
    output csp_pkg::cmd_t       push_cmd
);

    csp_pkg::coord_t older_x_reg, older_x_next;
    csp_pkg::coord_t older_y_reg, older_y_next;
    csp_pkg::coord_t newer_x_reg, newer_x_next;
    csp_pkg::coord_t newer_y_reg, newer_y_next;
    logic [1:0]      points_seen_reg, points_seen_next;
    logic            accept;

    assign point_stall = queue_full;
    assign accept      = point_valid && !queue_full;

    // the first point of a longer curve produces nothing yet
    assign push = accept && ((points_seen_reg != 2'd0) || point.curve_end);

    always_comb
    begin
        push_cmd.older_x       = older_x_reg;
        push_cmd.older_y       = older_y_reg;
        push_cmd.newer_x       = newer_x_reg;
        push_cmd.newer_y       = newer_y_reg;
        push_cmd.pt_x          = point.point_x;
        push_cmd.pt_y          = point.point_y;
        push_cmd.emit_pair     = (points_seen_reg != 2'd0);
        push_cmd.vertex_smooth = (points_seen_reg == 2'd2);
        push_cmd.emit_final    = point.curve_end;
    end

    always_comb
    begin
        older_x_next     = older_x_reg;
        older_y_next     = older_y_reg;
        newer_x_next     = newer_x_reg;
        newer_y_next     = newer_y_reg;
        points_seen_next = points_seen_reg;
        if (accept)
        begin
            if (point.curve_end)
            begin
                older_x_next     = '0;
                older_y_next     = '0;
                newer_x_next     = '0;
                newer_y_next     = '0;
                points_seen_next = 2'd0;
            end
            else
            begin
                older_x_next = newer_x_reg;
                older_y_next = newer_y_reg;
                newer_x_next = point.point_x;
                newer_y_next = point.point_y;
                if (points_seen_reg != 2'd2)
                begin
                    points_seen_next = points_seen_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_x_reg     <= '0;
            older_y_reg     <= '0;
            newer_x_reg     <= '0;
            newer_y_reg     <= '0;
            points_seen_reg <= 2'd0;
        end
        else
        begin
            older_x_reg     <= older_x_next;
            older_y_reg     <= older_y_next;
            newer_x_reg     <= newer_x_next;
            newer_y_reg     <= newer_y_next;
            points_seen_reg <= points_seen_next;
        end
    end

endmodule

// File: hdl/csp_queue.sv
// short command queue between front and back
// depends on csp_pkg
module csp_queue #(
    parameter int DEPTH = csp_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  csp_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output csp_pkg::cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    csp_pkg::cmd_t    slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hdl/csp_back.sv
// back end: turns one command into its result beats, one beat per cycle unless the output stalls
// depends on csp_pkg
module csp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  csp_pkg::cmd_t         head_cmd,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output csp_pkg::result_beat_t result
);

    localparam int EXT_W = csp_pkg::COORD_W + 2;

    typedef logic signed [EXT_W-1:0] ext_t;

    logic [1:0]            phase_reg, phase_next;
    logic                  valid_reg, valid_next;
    csp_pkg::result_beat_t beat_reg, beat_next;
    logic [1:0]            last_phase;
    logic                  load;
    logic                  take_vertex;
    logic                  take_mid;
    csp_pkg::coord_t       vert_x, vert_y;

    function automatic csp_pkg::coord_t midpoint(csp_pkg::coord_t u, csp_pkg::coord_t v);
        ext_t s;
        s = (ext_t'(u) + ext_t'(v)) >>> 1;
        return s[csp_pkg::COORD_W-1:0];
    endfunction

    // (p>>1) + (mid(a,p)>>2) + (mid(p,b)>>2), clamped
    function automatic csp_pkg::coord_t smooth(csp_pkg::coord_t a, csp_pkg::coord_t p,
                                               csp_pkg::coord_t b);
        ext_t ma;
        ext_t mb;
        ext_t sum;
        ext_t hi;
        ext_t lo;
        ma  = (ext_t'(a) + ext_t'(p)) >>> 1;
        mb  = (ext_t'(p) + ext_t'(b)) >>> 1;
        sum = (ext_t'(p) >>> 1) + (ma >>> 2) + (mb >>> 2);
        hi  = ext_t'({1'b0, {(csp_pkg::COORD_W-1){1'b1}}});
        lo  = ext_t'(csp_pkg::coord_t'({1'b1, {(csp_pkg::COORD_W-1){1'b0}}}));
        if (sum > hi)
        begin
            sum = hi;
        end
        else if (sum < lo)
        begin
            sum = lo;
        end
        return sum[csp_pkg::COORD_W-1:0];
    endfunction

    // beat order per command: vertex, midpoint, final point (each if present)
    assign last_phase  = head_cmd.emit_pair ? (head_cmd.emit_final ? 2'd2 : 2'd1) : 2'd0;
    assign take_vertex = head_cmd.emit_pair && (phase_reg == 2'd0);
    assign take_mid    = head_cmd.emit_pair && (phase_reg == 2'd1);
    assign load        = head_valid && (!valid_reg || !result_stall);
    assign pop         = load && (phase_reg == last_phase);

    assign vert_x = head_cmd.vertex_smooth
                  ? smooth(head_cmd.older_x, head_cmd.newer_x, head_cmd.pt_x)
                  : head_cmd.newer_x;
    assign vert_y = head_cmd.vertex_smooth
                  ? smooth(head_cmd.older_y, head_cmd.newer_y, head_cmd.pt_y)
                  : head_cmd.newer_y;

    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            phase_next = (phase_reg == last_phase) ? 2'd0 : phase_reg + 2'd1;
            if (take_vertex)
            begin
                beat_next.out_x       = vert_x;
                beat_next.out_y       = vert_y;
                beat_next.is_midpoint = 1'b0;
                beat_next.out_last    = 1'b0;
            end
            else if (take_mid)
            begin
                beat_next.out_x       = midpoint(head_cmd.newer_x, head_cmd.pt_x);
                beat_next.out_y       = midpoint(head_cmd.newer_y, head_cmd.pt_y);
                beat_next.is_midpoint = 1'b1;
                beat_next.out_last    = 1'b0;
            end
            else
            begin
                beat_next.out_x       = head_cmd.pt_x;
                beat_next.out_y       = head_cmd.pt_y;
                beat_next.is_midpoint = 1'b0;
                beat_next.out_last    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign result_valid = valid_reg;
    assign result       = beat_reg;

endmodule

// File: hdl/curve_subdivision_pass_unit.sv
// one open-curve b-spline subdivision pass over a stream of q12.4 points
// an accepted point's command is registered in the queue, then each beat in the output register
// throughput: a point is taken every cycle the queue has room; the back end emits one beat
// per cycle unless stalled: interior point 2 beats, closing point 3, lone point 1, first 0
// reset: rst_n clears the point window, the queue and the output valid flag
// depends on csp_pkg, csp_front, csp_queue, csp_back
module curve_subdivision_pass_unit #(
    parameter int QUEUE_DEPTH = csp_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  point_valid,
    output logic                  point_stall,
    input  csp_pkg::point_beat_t  point,
    output logic                  result_valid,
    input  logic                  result_stall,
    output csp_pkg::result_beat_t result
);

    // front to queue
    logic          push;
    csp_pkg::cmd_t push_cmd;
    logic          queue_full;

    // queue to back
    logic          pop;
    logic          head_valid;
    csp_pkg::cmd_t head_cmd;

    // front keeps the two-point window and decides which beats a point owes
    csp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .queue_full  (queue_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // decouples the input side from output stalls
    csp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // back does the smoothing and midpoint math and sequences the beats
    csp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
